@@ hdl/fqs_pkg.sv @@
// fqs_pkg: shared types, sizes and action codes for the fifo queue with search
// depends on nothing; used by hdl/fifo_queue_with_search.sv
package fqs_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = 5;
    localparam int WORD_W = 32;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic signed [WORD_W-1:0] t_word;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam t_word  EMPTY_FRONT = -32'sd1;
    localparam t_count DEPTH_CNT   = CNT_W'(DEPTH);
    localparam t_addr  LAST_SLOT   = ADDR_W'(DEPTH - 1);

    // ring pointer advance
    function automatic t_addr next_slot(input t_addr slot);
        t_addr nxt;
        nxt = (slot == LAST_SLOT) ? '0 : slot + t_addr'(1);
        return nxt;
    endfunction

endpackage

@@ hdl/fifo_queue_with_search.sv @@
// fifo_queue_with_search: bounded ring-buffer queue with push, pop and key search
// depends on hdl/fqs_pkg.sv
//
//  channel   handshake                 payload
//  ------    ---------                 -------
//  input     start & !busy             i_action, i_data_value
//  result    o_done (one cycle)        o_ok, o_popped_value, o_front_value,
//                                      o_is_empty, o_entry_count
//
//  push, a failed pop, search of an empty queue and the unused code finish straight from idle;
//  a pop passes through S_POP, as the new front comes from a read of the entry store;
//  a search walks the live entries, one store read per cycle, and stops at the first hit.
//  synchronous reset empties the queue; the entry store itself is not cleared.
//  results cannot be stalled; busy holds off new items while a pop or search runs.
module fifo_queue_with_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_action,
    input  logic signed [31:0]   i_data_value,
    output logic                 o_done,
    output logic                 o_ok,
    output logic signed [31:0]   o_popped_value,
    output logic signed [31:0]   o_front_value,
    output logic                 o_is_empty,
    output logic [4:0]           o_entry_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    fqs_pkg::t_word mem [fqs_pkg::DEPTH];

    logic [1:0]      r_state, n_state;
    fqs_pkg::t_addr  r_head, n_head;
    fqs_pkg::t_addr  r_tail, n_tail;
    fqs_pkg::t_addr  r_ptr, n_ptr;
    fqs_pkg::t_count r_count, n_count;
    fqs_pkg::t_count r_issued, n_issued;
    fqs_pkg::t_word  r_front, n_front;
    fqs_pkg::t_word  r_key, n_key;
    fqs_pkg::t_word  r_popped, n_popped;
    fqs_pkg::t_word  r_rd_data;
    logic            r_done, n_done;
    logic            r_ok, n_ok;

    logic            rd_en, wr_en;
    fqs_pkg::t_addr  rd_addr;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_ptr    = r_ptr;
        n_count  = r_count;
        n_issued = r_issued;
        n_front  = r_front;
        n_key    = r_key;
        n_popped = r_popped;
        n_ok     = r_ok;
        n_done   = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ok     = 1'b0;
                    n_popped = '0;
                    n_key    = i_data_value;
                    unique case (i_action)
                        fqs_pkg::ACT_PUSH: begin
                            n_done = 1'b1;
                            if (r_count < fqs_pkg::DEPTH_CNT) begin
                                wr_en   = 1'b1;
                                n_tail  = fqs_pkg::next_slot(r_tail);
                                n_count = r_count + fqs_pkg::t_count'(1);
                                n_ok    = 1'b1;
                                if (r_count == '0) begin
                                    n_front = i_data_value;
                                end
                            end
                        end
                        fqs_pkg::ACT_POP: begin
                            if (r_count != '0) begin
                                n_ok     = 1'b1;
                                n_popped = r_front;
                                n_head   = fqs_pkg::next_slot(r_head);
                                n_count  = r_count - fqs_pkg::t_count'(1);
                                // fetch the entry behind the head as the new front
                                rd_en    = 1'b1;
                                rd_addr  = fqs_pkg::next_slot(r_head);
                                n_state  = S_POP;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        fqs_pkg::ACT_SEARCH: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = r_head;
                                n_ptr    = fqs_pkg::next_slot(r_head);
                                n_issued = fqs_pkg::t_count'(1);
                                n_state  = S_SRCH;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_front = (r_count != '0) ? r_rd_data : fqs_pkg::EMPTY_FRONT;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SRCH: begin
                priority if (r_rd_data == r_key) begin
                    n_ok    = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_issued == r_count) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = r_ptr;
                    n_ptr    = fqs_pkg::next_slot(r_ptr);
                    n_issued = r_issued + fqs_pkg::t_count'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= i_data_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_front  <= fqs_pkg::EMPTY_FRONT;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_front  <= n_front;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_issued <= n_issued;
        r_key    <= n_key;
        r_popped <= n_popped;
        r_ok     <= n_ok;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_popped_value = r_popped;
    assign o_front_value  = r_front;
    assign o_is_empty     = (r_count == '0);
    assign o_entry_count  = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fqs_pkg::DEPTH_CNT)
        else $error("entry count above depth");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && (r_state == S_IDLE) |-> r_front == fqs_pkg::EMPTY_FRONT)
        else $error("empty queue shows a front value");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_count))
        else $error("count moved while a pop or search ran");

    a_search_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_count != '0) && (r_issued <= r_count))
        else $error("search walked past the live entries");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while still busy");
`endif

endmodule
